// ===== src/ups_sw_pkg.sv =====
// ----------------------------------------------------------------------------
// UPS switchover package
// Shared types, constants and register indexes of the switchover controller.
// ----------------------------------------------------------------------------
package ups_sw_pkg;

    localparam int CHANNELS         = 5;
    localparam int TICKS_PER_SECOND = 100;
    localparam int SAMPLE_FIELDS    = 5;

    localparam int SAMPLE_W  = 10;
    localparam int TICK_W    = 8;
    localparam int DIV_W     = 7;
    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 10;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [SAMPLE_W-1:0] STAT_MIN_RESET = SAMPLE_W'(1023);
    localparam logic [SAMPLE_W-1:0] STAT_MAX_RESET = '0;
    localparam logic [DIV_W-1:0]    DIV_RELOAD     = DIV_W'(TICKS_PER_SECOND);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LOW     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_OK     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAINS_OK       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAT_WARNING    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAT_CRITICAL   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BAT_HOLDOFF    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAINS_HOLDOFF  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BAT_SEC    = 8'd7;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_MEASURE     = 2'd1,
        OP_STATS_QUERY = 2'd2,
        OP_STATS_RESET = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 opcode;
        logic [SAMPLE_W-1:0] u_mains;
        logic [SAMPLE_W-1:0] u_battery_single;
        logic [SAMPLE_W-1:0] u_battery_pair;
        logic [SAMPLE_W-1:0] u_buffer;
        logic [SAMPLE_W-1:0] u_current;
        logic [CHAN_W-1:0]   channel_number;
    } cmd_item_t;

    typedef struct packed {
        logic                on_battery_now;
        logic                mode_changed;
        logic                buffer_ok_flag;
        logic                mains_low_flag;
        logic                battery_warning_flag;
        logic                battery_critical_flag;
        logic                stats_valid;
        logic [CHAN_W-1:0]   stats_channel;
        logic [SAMPLE_W-1:0] stats_minimum;
        logic [SAMPLE_W-1:0] stats_maximum;
    } rsp_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } cfg_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] buffer_low_threshold;
        logic [SAMPLE_W-1:0] battery_ok_threshold;
        logic [SAMPLE_W-1:0] mains_ok_threshold;
        logic [SAMPLE_W-1:0] battery_warning_level;
        logic [SAMPLE_W-1:0] battery_critical_level;
        logic [TICK_W-1:0]   battery_holdoff_ticks;
        logic [TICK_W-1:0]   mains_holdoff_ticks;
        logic [TICK_W-1:0]   min_battery_seconds;
    } cfg_regs_t;

    typedef struct packed {
        logic battery_mode;
        logic changed;
        logic buffer_ok;
        logic mains_low;
        logic bat_warning;
        logic bat_critical;
    } ctrl_status_t;

    typedef struct packed {
        logic                valid;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] minimum;
        logic [SAMPLE_W-1:0] maximum;
    } stats_result_t;

endpackage

// ===== src/ups_sw_if.sv =====
// ----------------------------------------------------------------------------
// UPS switchover channel interfaces
// Valid/ready channels for command items, result items and register writes.
// ----------------------------------------------------------------------------
interface ups_sw_cmd_if;
    logic                  valid;
    logic                  ready;
    ups_sw_pkg::cmd_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ups_sw_rsp_if;
    logic                  valid;
    logic                  ready;
    ups_sw_pkg::rsp_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ups_sw_cfg_if;
    logic                  valid;
    logic                  ready;
    ups_sw_pkg::cfg_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ups_sw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// UPS switchover configuration registers
// Holds the thresholds, hold-off loads and minimum battery time.
// ----------------------------------------------------------------------------
module ups_sw_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    ups_sw_cfg_if.sink            cfg,
    output ups_sw_pkg::cfg_regs_t regs
);

    ups_sw_pkg::cfg_regs_t regs_reg;
    ups_sw_pkg::cfg_regs_t regs_next;
    logic [ups_sw_pkg::SAMPLE_W-1:0] wr_level;
    logic [ups_sw_pkg::TICK_W-1:0]   wr_ticks;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;
    assign wr_level  = cfg.payload.data[ups_sw_pkg::SAMPLE_W-1:0];
    assign wr_ticks  = cfg.payload.data[ups_sw_pkg::TICK_W-1:0];

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            // Writes to indexes beyond the register list are dropped.
            unique case (cfg.payload.index)
                ups_sw_pkg::CFG_BUFFER_LOW:    regs_next.buffer_low_threshold   = wr_level;
                ups_sw_pkg::CFG_BATTERY_OK:    regs_next.battery_ok_threshold   = wr_level;
                ups_sw_pkg::CFG_MAINS_OK:      regs_next.mains_ok_threshold     = wr_level;
                ups_sw_pkg::CFG_BAT_WARNING:   regs_next.battery_warning_level  = wr_level;
                ups_sw_pkg::CFG_BAT_CRITICAL:  regs_next.battery_critical_level = wr_level;
                ups_sw_pkg::CFG_BAT_HOLDOFF:   regs_next.battery_holdoff_ticks  = wr_ticks;
                ups_sw_pkg::CFG_MAINS_HOLDOFF: regs_next.mains_holdoff_ticks    = wr_ticks;
                ups_sw_pkg::CFG_MIN_BAT_SEC:   regs_next.min_battery_seconds    = wr_ticks;
                default:                       regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.buffer_low_threshold   <= 10'd784;
            regs_reg.battery_ok_threshold   <= 10'd819;
            regs_reg.mains_ok_threshold     <= 10'd819;
            regs_reg.battery_warning_level  <= 10'd836;
            regs_reg.battery_critical_level <= 10'd829;
            regs_reg.battery_holdoff_ticks  <= 8'd200;
            regs_reg.mains_holdoff_ticks    <= 8'd10;
            regs_reg.min_battery_seconds    <= 8'd30;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== src/ups_sw_stats.sv =====
// ----------------------------------------------------------------------------
// UPS switchover channel statistics
// Per-channel minimum and maximum, cleared on request and read by query.
// ----------------------------------------------------------------------------
module ups_sw_stats (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  ups_sw_pkg::cmd_item_t     item,
    output ups_sw_pkg::stats_result_t result
);

    logic [ups_sw_pkg::SAMPLE_W-1:0] samples    [ups_sw_pkg::SAMPLE_FIELDS];
    logic [ups_sw_pkg::SAMPLE_W-1:0] min_reg    [ups_sw_pkg::CHANNELS];
    logic [ups_sw_pkg::SAMPLE_W-1:0] max_reg    [ups_sw_pkg::CHANNELS];
    logic                            do_measure;
    logic                            do_clear;
    logic                            chan_ok;
    logic [ups_sw_pkg::CHAN_W-1:0]   chan_off;
    logic [ups_sw_pkg::CH_IDX_W-1:0] chan_idx;

    assign samples[0] = item.u_mains;
    assign samples[1] = item.u_battery_single;
    assign samples[2] = item.u_battery_pair;
    assign samples[3] = item.u_buffer;
    assign samples[4] = item.u_current;

    assign do_measure = accept && (item.opcode == ups_sw_pkg::OP_MEASURE);
    assign do_clear   = accept && (item.opcode == ups_sw_pkg::OP_STATS_RESET);

    genvar g;
    generate
        for (g = 0; g < ups_sw_pkg::CHANNELS; g++)
        begin : g_chan
            if (g < ups_sw_pkg::SAMPLE_FIELDS)
            begin : g_sampled
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        min_reg[g] <= ups_sw_pkg::STAT_MIN_RESET;
                        max_reg[g] <= ups_sw_pkg::STAT_MAX_RESET;
                    end
                    else if (do_clear)
                    begin
                        min_reg[g] <= ups_sw_pkg::STAT_MIN_RESET;
                        max_reg[g] <= ups_sw_pkg::STAT_MAX_RESET;
                    end
                    else if (do_measure)
                    begin
                        if (samples[g] < min_reg[g])
                        begin
                            min_reg[g] <= samples[g];
                        end
                        if (samples[g] > max_reg[g])
                        begin
                            max_reg[g] <= samples[g];
                        end
                    end
                end
            end
            else
            begin : g_unsampled
                // Channels with no sample field keep their cleared values.
                assign min_reg[g] = ups_sw_pkg::STAT_MIN_RESET;
                assign max_reg[g] = ups_sw_pkg::STAT_MAX_RESET;
            end
        end
    endgenerate

    assign chan_ok  = (item.channel_number != '0)
                   && (item.channel_number <= ups_sw_pkg::CHAN_W'(ups_sw_pkg::CHANNELS));
    assign chan_off = item.channel_number - ups_sw_pkg::CHAN_W'(1);
    assign chan_idx = chan_off[ups_sw_pkg::CH_IDX_W-1:0];

    always_comb
    begin
        result = '0;
        if (item.opcode == ups_sw_pkg::OP_STATS_QUERY)
        begin
            result.channel = item.channel_number;
            if (chan_ok)
            begin
                result.valid   = 1'b1;
                result.minimum = min_reg[chan_idx];
                result.maximum = max_reg[chan_idx];
            end
        end
    end

endmodule

// ===== src/ups_sw_ctrl.sv =====
// ----------------------------------------------------------------------------
// UPS switchover decision logic
// Mode, hold-off timer, seconds counter and indicator flags.
// ----------------------------------------------------------------------------
module ups_sw_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  ups_sw_pkg::cmd_item_t    item,
    input  ups_sw_pkg::cfg_regs_t    regs,
    output ups_sw_pkg::ctrl_status_t status
);

    logic                          mode_reg,    mode_next;
    logic [ups_sw_pkg::TICK_W-1:0] holdoff_reg, holdoff_next;
    logic [ups_sw_pkg::DIV_W-1:0]  div_reg,     div_next;
    logic [ups_sw_pkg::TICK_W-1:0] seconds_reg, seconds_next;
    logic [3:0]                    flags_reg,   flags_next;
    logic                          changed;
    logic                          buf_failing;

    assign buf_failing = item.u_buffer <= regs.buffer_low_threshold;

    always_comb
    begin
        mode_next    = mode_reg;
        holdoff_next = holdoff_reg;
        div_next     = div_reg;
        seconds_next = seconds_reg;
        flags_next   = flags_reg;
        changed      = 1'b0;
        case (item.opcode)
            ups_sw_pkg::OP_TICK:
            begin
                if (holdoff_reg != '0)
                begin
                    holdoff_next = holdoff_reg - 1'b1;
                end
                // A second spans one tick more than the reload value.
                if (div_reg == '0)
                begin
                    div_next = ups_sw_pkg::DIV_RELOAD;
                    if (seconds_reg != '0)
                    begin
                        seconds_next = seconds_reg - 1'b1;
                    end
                end
                else
                begin
                    div_next = div_reg - 1'b1;
                end
            end
            ups_sw_pkg::OP_MEASURE:
            begin
                if (holdoff_reg == '0)
                begin
                    if (buf_failing)
                    begin
                        if (item.u_battery_pair > regs.battery_ok_threshold)
                        begin
                            if (!mode_reg)
                            begin
                                mode_next    = 1'b1;
                                holdoff_next = regs.battery_holdoff_ticks;
                                seconds_next = regs.min_battery_seconds;
                                changed      = 1'b1;
                            end
                        end
                        else if (mode_reg)
                        begin
                            mode_next    = 1'b0;
                            holdoff_next = regs.mains_holdoff_ticks;
                            changed      = 1'b1;
                        end
                    end
                    else if (item.u_mains > regs.mains_ok_threshold
                             && seconds_reg == '0 && mode_reg)
                    begin
                        mode_next    = 1'b0;
                        holdoff_next = regs.mains_holdoff_ticks;
                        changed      = 1'b1;
                    end
                    flags_next[0] = item.u_buffer >= regs.buffer_low_threshold;
                    flags_next[1] = item.u_mains < regs.buffer_low_threshold;
                    flags_next[2] = item.u_battery_pair < regs.battery_warning_level;
                    flags_next[3] = item.u_battery_pair < regs.battery_critical_level;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            holdoff_reg <= '0;
            div_reg     <= '0;
            seconds_reg <= '0;
            flags_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            holdoff_reg <= holdoff_next;
            div_reg     <= div_next;
            seconds_reg <= seconds_next;
            flags_reg   <= flags_next;
        end
    end

    assign status.battery_mode = mode_next;
    assign status.changed      = changed;
    assign status.buffer_ok    = flags_next[0];
    assign status.mains_low    = flags_next[1];
    assign status.bat_warning  = flags_next[2];
    assign status.bat_critical = flags_next[3];

endmodule

// ===== src/ups_switchover_controller.sv =====
// ----------------------------------------------------------------------------
// UPS switchover controller
// Chooses mains or battery from measured voltages, keeps channel statistics.
// ----------------------------------------------------------------------------
// Every command item yields exactly one result item. An item is accepted in
// any cycle in which the result register is empty or its item is being taken,
// so one item per clock is sustained; the result appears in the cycle after
// acceptance. The state update and all compares of an item happen in the
// accepting cycle, from the item and the current state, straight into the
// result register. Register writes are taken in every cycle and should only
// be issued while no item is in flight. The statistics reset to their
// cleared values at once; there is no clearing pass.
module ups_switchover_controller (
    input logic        clk,
    input logic        rst_n,
    ups_sw_cmd_if.sink   cmd,
    ups_sw_rsp_if.source rsp,
    ups_sw_cfg_if.sink   cfg
);

    ups_sw_pkg::cfg_regs_t     regs;
    ups_sw_pkg::ctrl_status_t  status;
    ups_sw_pkg::stats_result_t stats;
    ups_sw_pkg::rsp_item_t     rsp_reg;
    ups_sw_pkg::rsp_item_t     rsp_next;
    logic                      rsp_valid_reg;
    logic                      accept;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    ups_sw_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    ups_sw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (cmd.payload),
        .regs   (regs),
        .status (status)
    );

    ups_sw_stats u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (cmd.payload),
        .result (stats)
    );

    always_comb
    begin
        rsp_next.on_battery_now        = status.battery_mode;
        rsp_next.mode_changed          = status.changed;
        rsp_next.buffer_ok_flag        = status.buffer_ok;
        rsp_next.mains_low_flag        = status.mains_low;
        rsp_next.battery_warning_flag  = status.bat_warning;
        rsp_next.battery_critical_flag = status.bat_critical;
        rsp_next.stats_valid           = stats.valid;
        rsp_next.stats_channel         = stats.channel;
        rsp_next.stats_minimum         = stats.minimum;
        rsp_next.stats_maximum         = stats.maximum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            rsp_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

endmodule
